@@ hdl/btp_pkg.sv @@
package btp_pkg;

    localparam int BTP_MAX_WIDTH = 1024;

    localparam int IMG_W_BITS = 11;
    localparam int IMG_H_BITS = 12;
    localparam int CFG_DATA_BITS = 12;
    localparam int CFG_INDEX_BITS = 1;
    // row counter runs past the frame, up to height + 2, while the pipeline drains
    localparam int ROW_BITS = 13;

    localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd640;
    localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 12'd480;
    localparam logic [IMG_W_BITS-1:0] IMG_W_MIN = 11'd4;
    localparam logic [IMG_H_BITS-1:0] IMG_H_MIN = 12'd4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic SUB_FIRST = 1'b0;
    localparam logic SUB_SECOND = 1'b1;

    localparam logic [3:0] SET_MIN = 4'd2;
    localparam logic [3:0] SET_MAX = 4'd6;

    // per-beat flags computed from the raster position at the input
    typedef struct packed {
        logic pix;      // pixel bit (zero during drain)
        logic int1;     // first stage centre is interior
        logic int2;     // second stage centre is interior
        logic res;      // beat yields a result
        logic last;     // result is the final pixel of the frame
    } pix_tag_t;

    // ring order: n, ne, e, se, s, sw, w, nw in bits 0..7
    function automatic logic zs_clear(input logic [7:0] r, input logic sub);
        logic [7:0] rise;
        logic [3:0] a;
        logic [3:0] b;
        logic m1;
        logic m2;
        rise = ~r & {r[0], r[7:1]};
        a = '0;
        b = '0;
        for (int i = 0; i < 8; i++) begin
            a = a + {3'b000, rise[i]};
            b = b + {3'b000, r[i]};
        end
        if (sub == SUB_FIRST) begin
            m1 = r[0] & r[2] & r[4];
            m2 = r[2] & r[4] & r[6];
        end
        else begin
            m1 = r[0] & r[2] & r[6];
            m2 = r[0] & r[4] & r[6];
        end
        return (a == 4'd1) && (b >= SET_MIN) && (b <= SET_MAX) && !m1 && !m2;
    endfunction

    // window cell k = column * 3 + row, column 0 west, row 0 north
    function automatic logic [7:0] ring_1b(input logic [8:0] win);
        return {win[0], win[1], win[2], win[5], win[8], win[7], win[6], win[3]};
    endfunction

    // two bits per cell; bit 0 of each cell is the stage-one value
    function automatic logic [7:0] ring_2b(input logic [17:0] win);
        return {win[0], win[2], win[4], win[10], win[16], win[14], win[12], win[6]};
    endfunction

endpackage

@@ hdl/btp_ram.sv @@
module btp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/btp_seq.sv @@
module btp_seq
    import btp_pkg::*;
#(
    parameter int MAX_WIDTH = BTP_MAX_WIDTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 command,
    input  logic                                 pixel_in,
    input  logic                                 adv,
    input  logic                                 clear,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]       width,
    input  logic [IMG_H_BITS-1:0]                height,
    output logic                                 take,
    output logic [$clog2(MAX_WIDTH)-1:0]         col,
    output pix_tag_t                             tag
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic [ROW_BITS-1:0] row_reg;
    logic [ROW_BITS-1:0] row_next;
    logic [ROW_BITS-1:0] h_ext;
    logic                drain;
    logic                row_end;

    assign h_ext = ROW_BITS'(height);
    assign drain = row_reg >= h_ext;
    assign take = in_valid & adv & (drain | (command == CMD_PIXEL));
    assign col = col_reg;
    assign row_end = (WW'(col_reg) + WW'(1)) == width;

    // first stage centre trails by one row and one pixel, second by two of each
    always_comb
    begin
        tag.pix = drain ? 1'b0 : pixel_in;
        tag.int1 = (col_reg >= CW'(2)) && (row_reg >= ROW_BITS'(2))
                   && (row_reg <= h_ext - ROW_BITS'(1));
        tag.int2 = ((col_reg >= CW'(3)) && (row_reg >= ROW_BITS'(3)) && (row_reg <= h_ext))
                   || ((col_reg == CW'(0)) && (row_reg >= ROW_BITS'(4))
                       && (row_reg <= h_ext + ROW_BITS'(1)));
        tag.res = (row_reg >= ROW_BITS'(3))
                  || ((row_reg == ROW_BITS'(2)) && (col_reg >= CW'(2)));
        tag.last = (col_reg == CW'(1)) && (row_reg == h_ext + ROW_BITS'(2));
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        priority if (clear)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (take)
        begin
            if (tag.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (row_end)
            begin
                col_next = '0;
                row_next = row_reg + ROW_BITS'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ hdl/binary_thinning_pass.sv @@
// The result for pixel p comes from the beat of item p + 2W + 2, via stages b, c, d and the output register.
// Throughput: one item per cycle; each line buffer does one read and one write per cycle.
// Stalls only when the output register holds a result that is not taken.
// Reset: W = 640, H = 480, raster position, pipeline and change flag cleared; line buffers
// are not cleared, as every value a result uses is written earlier in the same frame.
module binary_thinning_pass
    import btp_pkg::*;
#(
    parameter int MAX_WIDTH = BTP_MAX_WIDTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      command,
    input  logic                      pixel_in,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      pixel_out,
    output logic                      pixel_changed,
    output logic                      frame_changed,
    output logic                      last_of_frame,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [IMG_W_BITS-1:0] image_width_reg;
    logic [IMG_W_BITS-1:0] image_width_next;
    logic [IMG_H_BITS-1:0] image_height_reg;
    logic [IMG_H_BITS-1:0] image_height_next;
    logic [WW-1:0]         width_eff;
    logic [IMG_H_BITS-1:0] height_eff;

    logic                  adv;
    logic                  take;
    logic [CW-1:0]         col_a;
    pix_tag_t              tag_a;

    logic                  vb_reg, vc_reg, vd_reg;
    logic [CW-1:0]         col_b_reg, col_c_reg;
    pix_tag_t              tag_b_reg, tag_c_reg, tag_d_reg;

    logic [1:0]            rows1_rdata;
    logic [1:0]            rows1_wdata;
    logic [3:0]            rows2_rdata;
    logic [3:0]            rows2_wdata;

    logic [8:0]            win1_reg, win1_next;
    logic [17:0]           win2_reg, win2_next;

    logic                  clr1, clr2;
    logic                  me;
    logic [1:0]            pair;
    logic                  v_out;
    logic                  changed;
    logic                  load;

    logic                  out_valid_reg, out_valid_next;
    logic                  pixel_out_reg, pixel_changed_reg;
    logic                  frame_changed_reg, last_of_frame_reg;
    logic                  change_seen_reg, change_seen_next;

    // configuration
    always_comb
    begin
        image_width_next = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_next = cfg_data[IMG_W_BITS-1:0];
                REG_IMAGE_HEIGHT: image_height_next = cfg_data[IMG_H_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg < IMG_W_MIN)
            width_eff = WW'(IMG_W_MIN);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            width_eff = WW'(MAX_WIDTH);
        else
            width_eff = WW'(image_width_reg);
        height_eff = (image_height_reg < IMG_H_MIN) ? IMG_H_MIN : image_height_reg;
    end

    // whole pipeline moves together; it holds only while a result waits
    assign adv = !out_valid_reg || out_ready;
    assign in_ready = adv;

    btp_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .pixel_in (pixel_in),
        .adv      (adv),
        .clear    (cfg_write),
        .width    (width_eff),
        .height   (height_eff),
        .take     (take),
        .col      (col_a),
        .tag      (tag_a)
    );

    // first stage line buffer: bit 1 = row above, bit 0 = current row
    assign rows1_wdata = {rows1_rdata[0], tag_b_reg.pix};
    assign win1_next = {tag_b_reg.pix, rows1_rdata[0], rows1_rdata[1], win1_reg[8:3]};

    btp_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_rows1 (
        .clk   (clk),
        .we    (adv & vb_reg),
        .waddr (col_b_reg),
        .wdata (rows1_wdata),
        .re    (take),
        .raddr (col_a),
        .rdata (rows1_rdata)
    );

    // first sub-iteration; pair = {original, stage-one value}
    assign me = win1_reg[4];
    assign clr1 = zs_clear(ring_1b(win1_reg), SUB_FIRST);
    assign pair = {me, me & ~(tag_c_reg.int1 & clr1)};

    assign rows2_wdata = {rows2_rdata[1:0], pair};
    assign win2_next = {pair, rows2_rdata[1:0], rows2_rdata[3:2], win2_reg[17:6]};

    btp_ram #(
        .WIDTH (4),
        .DEPTH (MAX_WIDTH)
    ) u_rows2 (
        .clk   (clk),
        .we    (adv & vc_reg),
        .waddr (col_c_reg),
        .wdata (rows2_wdata),
        .re    (adv & vb_reg),
        .raddr (col_b_reg),
        .rdata (rows2_rdata)
    );

    // second sub-iteration
    assign clr2 = zs_clear(ring_2b(win2_reg), SUB_SECOND);
    assign v_out = win2_reg[8] & ~(tag_d_reg.int2 & clr2);
    assign changed = win2_reg[9] & ~v_out;
    assign load = adv & vd_reg & tag_d_reg.res;

    always_comb
    begin
        change_seen_next = change_seen_reg;
        out_valid_next = out_valid_reg;
        priority if (cfg_write)
        begin
            change_seen_next = 1'b0;
        end
        else if (load)
        begin
            change_seen_next = tag_d_reg.last ? 1'b0 : (change_seen_reg | changed);
        end
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMG_W_RESET;
            image_height_reg <= IMG_H_RESET;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            win1_reg <= '0;
            win2_reg <= '0;
            change_seen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            image_width_reg <= image_width_next;
            image_height_reg <= image_height_next;
            if (adv)
            begin
                vb_reg <= take;
                vc_reg <= vb_reg;
                vd_reg <= vc_reg;
                if (vb_reg)
                    win1_reg <= win1_next;
                if (vc_reg)
                    win2_reg <= win2_next;
            end
            change_seen_reg <= change_seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            col_b_reg <= col_a;
            col_c_reg <= col_b_reg;
            tag_b_reg <= tag_a;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
        end
        if (load)
        begin
            pixel_out_reg <= v_out;
            pixel_changed_reg <= changed;
            frame_changed_reg <= tag_d_reg.last & (change_seen_reg | changed);
            last_of_frame_reg <= tag_d_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;
    assign pixel_changed = pixel_changed_reg;
    assign frame_changed = frame_changed_reg;
    assign last_of_frame = last_of_frame_reg;

`ifndef SYNTHESIS
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (vd_reg && tag_d_reg.res && adv) |=> out_valid)
        else $error("result beat lost at the output register");

    a_frame_flag_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_changed) |-> last_of_frame)
        else $error("frame_changed raised away from the last pixel");

    a_changed_is_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pixel_changed) |-> !pixel_out)
        else $error("changed pixel still set");

    a_window_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(win1_reg) && $stable(win2_reg)))
        else $error("window shifted during a stall");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import btp_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 850;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic pixel_out;
        logic pixel_changed;
        logic frame_changed;
        logic last_of_frame;
    } thinned_pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic command = CMD_PIXEL;
    logic pixel_in = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic pixel_out;
    logic pixel_changed;
    logic frame_changed;
    logic last_of_frame;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // thinning predictor state
    logic [IMG_W_BITS-1:0] model_width = IMG_W_RESET;
    logic [IMG_H_BITS-1:0] model_height = IMG_H_RESET;
    logic [BTP_MAX_WIDTH-1:0] s1_top = '0;
    logic [BTP_MAX_WIDTH-1:0] s1_mid = '0;
    logic [BTP_MAX_WIDTH-1:0] s2_top = '0;
    logic [BTP_MAX_WIDTH-1:0] s2_mid = '0;
    logic [BTP_MAX_WIDTH-1:0] orig_mid = '0;
    // window rows north/middle/south, bit 2 is the east column
    logic [2:0] s1_n = '0;
    logic [2:0] s1_m = '0;
    logic [2:0] s1_s = '0;
    logic [2:0] s2_n = '0;
    logic [2:0] s2_m = '0;
    logic [2:0] s2_s = '0;
    logic [2:0] orig_row = '0;
    int unsigned pixels_taken = 0;
    logic frame_dirty = 1'b0;

    thinned_pixel_t thinned_queue[$];
    int unsigned mismatch_count = 0;
    int unsigned items_fed = 0;
    int unsigned cycle_count = 0;
    int burst_left = 0;
    bit sender_idles = 1'b1;
    bit long_hold = 1'b0;

    binary_thinning_pass dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .pixel_in      (pixel_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_out     (pixel_out),
        .pixel_changed (pixel_changed),
        .frame_changed (frame_changed),
        .last_of_frame (last_of_frame),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic int unsigned effective_width();
        int unsigned w;
        w = model_width;
        if (w < IMG_W_MIN)
            w = IMG_W_MIN;
        if (w > BTP_MAX_WIDTH)
            w = BTP_MAX_WIDTH;
        return w;
    endfunction

    // 12-bit field cannot exceed the top of the range
    function automatic int unsigned effective_height();
        int unsigned h;
        h = model_height;
        if (h < IMG_H_MIN)
            h = IMG_H_MIN;
        return h;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                           input logic [CFG_DATA_BITS-1:0] data);
        if (idx == REG_IMAGE_WIDTH)
            model_width = data[IMG_W_BITS-1:0];
        else
            model_height = data[IMG_H_BITS-1:0];
        pixels_taken = 0;
        frame_dirty = 1'b0;
    endfunction

    function automatic logic inner_pixel(input int unsigned q, input int unsigned w,
                                         input int unsigned h);
        int unsigned row;
        int unsigned col;
        row = q / w;
        col = q % w;
        return row != 0 && row != h - 1 && col != 0 && col != w - 1;
    endfunction

    // ring bits 0..7: n, ne, e, se, s, sw, w, nw
    function automatic logic [7:0] neighbours(input logic [2:0] north, input logic [2:0] middle,
                                              input logic [2:0] south);
        return {north[0], middle[0], south[0], south[1], south[2], middle[2], north[2], north[1]};
    endfunction

    function automatic logic zs_removable(input logic [7:0] ring, input logic sub);
        int rises;
        int set_count;
        logic term_a;
        logic term_b;
        rises = 0;
        set_count = 0;
        for (int i = 0; i < 8; i++)
        begin
            if (!ring[i] && ring[(i + 1) % 8])
                rises++;
            if (ring[i])
                set_count++;
        end
        if (sub == SUB_FIRST)
        begin
            term_a = ring[0] & ring[2] & ring[4];
            term_b = ring[2] & ring[4] & ring[6];
        end
        else
        begin
            term_a = ring[0] & ring[2] & ring[6];
            term_b = ring[0] & ring[4] & ring[6];
        end
        return rises == 1 && set_count >= SET_MIN && set_count <= SET_MAX && !term_a && !term_b;
    endfunction

    // advance the two-stage thinning model by one accepted beat
    function automatic void predict_beat(input logic cmd, input logic pix);
        int unsigned w;
        int unsigned h;
        int unsigned frame_px;
        int unsigned n;
        int unsigned col;
        int unsigned q;
        int unsigned p;
        logic fresh;
        logic top1;
        logic mid1;
        logic centre1;
        logic out1;
        logic top2;
        logic mid2;
        logic orig2;
        logic centre2;
        logic [1:0] pair;
        thinned_pixel_t res;
        w = effective_width();
        h = effective_height();
        frame_px = w * h;
        n = pixels_taken;
        if (n < frame_px && cmd == CMD_FLUSH)
            return;
        fresh = (n < frame_px) ? pix : 1'b0;
        col = n % w;

        top1 = s1_top[col];
        mid1 = s1_mid[col];
        s1_top[col] = mid1;
        s1_mid[col] = fresh;
        s1_n = {top1, s1_n[2:1]};
        s1_m = {mid1, s1_m[2:1]};
        s1_s = {fresh, s1_s[2:1]};
        pair = 2'b00;   // {original, after first sub-iteration}
        if (n >= w + 1)
        begin
            q = n - w - 1;
            centre1 = s1_m[1];
            out1 = centre1;
            if (q < frame_px && centre1 && inner_pixel(q, w, h)
                && zs_removable(neighbours(s1_n, s1_m, s1_s), SUB_FIRST))
                out1 = 1'b0;
            pair = {centre1, out1};
        end

        top2 = s2_top[col];
        mid2 = s2_mid[col];
        orig2 = orig_mid[col];
        s2_top[col] = mid2;
        s2_mid[col] = pair[0];
        orig_mid[col] = pair[1];
        s2_n = {top2, s2_n[2:1]};
        s2_m = {mid2, s2_m[2:1]};
        s2_s = {pair[0], s2_s[2:1]};
        orig_row = {orig2, orig_row[2:1]};

        pixels_taken = n + 1;
        if (n < 2 * w + 2)
            return;
        p = n - 2 * w - 2;
        centre2 = s2_m[1];
        if (centre2 && inner_pixel(p, w, h)
            && zs_removable(neighbours(s2_n, s2_m, s2_s), SUB_SECOND))
            centre2 = 1'b0;
        res.pixel_out = centre2;
        res.pixel_changed = orig_row[1] & ~centre2;
        frame_dirty = frame_dirty | res.pixel_changed;
        res.last_of_frame = (p == frame_px - 1);
        res.frame_changed = res.last_of_frame & frame_dirty;
        thinned_queue.push_back(res);
        if (res.last_of_frame)
        begin
            pixels_taken = 0;
            frame_dirty = 1'b0;
        end
    endfunction

    task automatic pace();
        int gap;
        if (!sender_idles)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(0, 23);
    endtask

    task automatic send_item(input logic cmd, input logic pix);
        in_valid <= 1'b1;
        command <= cmd;
        pixel_in <= pix;
        do @(posedge clk); while (!in_ready);
        predict_beat(cmd, pix);
        pace();
    endtask

    task automatic configure(input int unsigned width_val, input int unsigned height_val);
        cfg_write <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= width_val;
        @(posedge clk);
        apply_register(REG_IMAGE_WIDTH, width_val);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= height_val;
        @(posedge clk);
        apply_register(REG_IMAGE_HEIGHT, height_val);
        cfg_write <= 1'b0;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (thinned_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one frame of pixels plus its drain; stop_after below w*h leaves it unfinished
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int unsigned stop_after);
        int unsigned kind;
        int unsigned r0;
        int unsigned r1;
        int unsigned c0;
        int unsigned c1;
        int unsigned row;
        int unsigned col;
        logic bit_val;
        kind = $urandom_range(0, 9);
        r0 = $urandom_range(0, h - 1);
        r1 = $urandom_range(r0, h - 1);
        c0 = $urandom_range(0, w - 1);
        c1 = $urandom_range(c0, w - 1);
        for (row = 0; row < h; row++)
        begin
            for (col = 0; col < w; col++)
            begin
                if (row * w + col >= stop_after)
                    return;
                case (kind)
                    0: bit_val = 1'b0;
                    1: bit_val = 1'b1;
                    2, 3, 4, 5: bit_val = $urandom_range(0, 9) < (kind - 1) * 2;
                    default: bit_val = (row >= r0 && row <= r1 && col >= c0 && col <= c1)
                                       ^ ($urandom_range(0, 15) == 0);
                endcase
                // stray flush inside the frame is dropped
                if ($urandom_range(0, 19) == 0)
                    send_item(CMD_FLUSH, $urandom_range(0, 1));
                send_item(CMD_PIXEL, bit_val);
                items_fed++;
            end
        end
        for (int i = 0; i < 2 * w + 2; i++)
        begin
            send_item(($urandom_range(0, 2) == 0) ? CMD_PIXEL : CMD_FLUSH, $urandom_range(0, 1));
            items_fed++;
        end
    endtask

    task automatic test_abandoned_frame();
        // reset size is 640x480: nothing comes out, the register write restarts the frame
        send_item(CMD_PIXEL, 1'b1);
        send_item(CMD_PIXEL, 1'b0);
        send_item(CMD_FLUSH, 1'b1);
        send_item(CMD_PIXEL, 1'b1);
        settle();
    endtask

    task automatic test_directed_frame();
        logic [15:0] blob;
        // 2x2 blob in a 4x4 frame: all four blob pixels go in the first sub-iteration
        blob = 16'h0660;
        configure(4, 4);
        send_item(CMD_FLUSH, 1'b1);
        for (int k = 0; k < 16; k++)
        begin
            if (k == 5)
                send_item(CMD_FLUSH, 1'b0);
            send_item(CMD_PIXEL, blob[k]);
        end
        // pixel beats past the frame only drain
        for (int k = 0; k < 10; k++)
            send_item(k[0] ? CMD_PIXEL : CMD_FLUSH, 1'b1);
        settle();
    endtask

    task automatic test_backpressure();
        configure(9, 7);
        sender_idles = 1'b0;
        long_hold = 1'b1;
        send_frame(9, 7, 63);
        sender_idles = 1'b1;
        settle();
    endtask

    task automatic test_random_frames();
        int unsigned goal;
        int unsigned w_raw;
        int unsigned h_raw;
        int unsigned w;
        int unsigned h;
        goal = items_fed + RANDOM_ITEMS;
        while (items_fed < goal)
        begin
            case ($urandom_range(0, 7))
                0: w_raw = $urandom_range(0, 3);
                1: w_raw = $urandom_range(13, 24);
                default: w_raw = $urandom_range(4, 12);
            endcase
            h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 10);
            configure(w_raw, h_raw);
            w = effective_width();
            h = effective_height();
            sender_idles = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(1, 3)) send_frame(w, h, w * h);
            if ($urandom_range(0, 7) == 0)
                send_frame(w, h, $urandom_range(1, w * h - 1));
            settle();
        end
        sender_idles = 1'b1;
    endtask

    task automatic test_size_extremes();
        // all-ones width saturates to the widest row, zero height to the fewest rows
        configure((1 << IMG_W_BITS) - 1, 0);
        send_frame(effective_width(), effective_height(), effective_width() * effective_height());
        settle();
        configure(0, (1 << IMG_H_BITS) - 1);
        send_frame(effective_width(), effective_height(), effective_width() * effective_height());
        settle();
    endtask

    task automatic check_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        thinned_pixel_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (thinned_queue.size() == 0)
            begin
                $error("result beat with nothing outstanding");
                mismatch_count++;
            end
            else
            begin
                want = thinned_queue.pop_front();
                check_field("pixel_out", want.pixel_out, pixel_out);
                check_field("pixel_changed", want.pixel_changed, pixel_changed);
                check_field("frame_changed", want.frame_changed, frame_changed);
                check_field("last_of_frame", want.last_of_frame, last_of_frame);
            end
        end
    end

    initial
    begin : receiver
        int mode;
        int span;
        int phase;
        int hold;
        mode = 0;
        span = 0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                for (hold = 0; hold < LONG_HOLD_CYCLES; hold++)
                    @(posedge clk);
                long_hold = 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(16, 96);
                end
                span--;
                phase = (phase + 1) % 3;
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (phase != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_abandoned_frame();
        test_directed_frame();
        test_backpressure();
        test_random_frames();
        test_size_extremes();
        settle();
        if (mismatch_count == 0 && thinned_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
